// File: design/sgm_pkg.sv
package sgm_pkg;

    // Pattern store depth and automaton width (one extra position for "all consumed").
    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;

    localparam logic [7:0] WILDCARD_BYTE = 8'd42;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_EVAL = 2'd2
    } cmd_t;

    // What the automaton needs from the pattern store.
    typedef struct packed {
        logic [PATTERN_MAX-1:0] mask;       // positions below pattern length
        logic [PATTERN_MAX-1:0] star;       // wildcard positions, already masked
        logic [POS_W-1:0]       end_pos;    // one-hot at pattern length
        logic [POS_W-1:0]       start_vec;  // closure of position zero
        logic                   overflow;
    } pat_view_t;

    typedef struct packed {
        logic has_result;
        logic matched;
        logic overflow;
    } result_t;

    // Wildcard closure: an active position on a run of wildcards activates
    // the rest of the run above it and the position after it. A carry chain does the fill.
    function automatic logic [POS_W-1:0] star_closure(
        input logic [POS_W-1:0]       v,
        input logic [PATTERN_MAX-1:0] s
    );
        logic [POS_W-1:0] s_ext;
        logic [POS_W-1:0] filled;
        s_ext  = {1'b0, s};
        filled = (v & s_ext) + s_ext;
        return v | (filled ^ s_ext);
    endfunction

endpackage

// File: design/sgm_pattern_store.sv
module sgm_pattern_store (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_en,
    input  logic                     load_first,
    input  logic [7:0]               load_char,
    output logic [7:0]               pat_bytes [sgm_pkg::PATTERN_MAX],
    output sgm_pkg::pat_view_t       view
);

    logic [7:0]                         bytes_reg [sgm_pkg::PATTERN_MAX];
    logic [sgm_pkg::PATTERN_MAX-1:0]    star_reg;
    logic [sgm_pkg::PATTERN_MAX-1:0]    star_next;
    logic [sgm_pkg::PATTERN_MAX-1:0]    mask_reg;
    logic [sgm_pkg::PATTERN_MAX-1:0]    mask_next;
    logic [sgm_pkg::POS_W-1:0]          end_reg;
    logic [sgm_pkg::POS_W-1:0]          end_next;
    logic [sgm_pkg::POS_W-1:0]          start_reg;
    logic [sgm_pkg::POS_W-1:0]          start_next;
    logic                               ovf_reg;
    logic                               ovf_next;

    logic [sgm_pkg::PATTERN_MAX-1:0]    mask_base;
    logic [sgm_pkg::POS_W-1:0]          end_base;
    logic                               ovf_base;
    logic [sgm_pkg::PATTERN_MAX-1:0]    wr_en;
    logic                               is_star;
    logic                               full;

    always_comb
    begin
        mask_base = load_first ? '0 : mask_reg;
        end_base  = load_first ? sgm_pkg::POS_W'(1) : end_reg;
        ovf_base  = load_first ? 1'b0 : ovf_reg;
        is_star   = (load_char == sgm_pkg::WILDCARD_BYTE);
        full      = end_base[sgm_pkg::PATTERN_MAX];
        // write slot is the current end position; none when full
        wr_en     = end_base[sgm_pkg::PATTERN_MAX-1:0];
        star_next = (star_reg & ~wr_en) | (wr_en & {sgm_pkg::PATTERN_MAX{is_star}});
        if (full)
        begin
            mask_next = mask_base;
            end_next  = end_base;
            ovf_next  = 1'b1;
        end
        else
        begin
            mask_next = mask_base | wr_en;
            end_next  = end_base << 1;
            ovf_next  = ovf_base;
        end
        start_next = sgm_pkg::star_closure(sgm_pkg::POS_W'(1), star_next & mask_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            end_reg   <= sgm_pkg::POS_W'(1);
            start_reg <= sgm_pkg::POS_W'(1);
            ovf_reg   <= 1'b0;
        end
        else if (load_en)
        begin
            mask_reg  <= mask_next;
            end_reg   <= end_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Pattern payload; entries beyond the mask are never looked at.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            star_reg <= star_next;
            for (int i = 0; i < sgm_pkg::PATTERN_MAX; i++)
            begin
                if (wr_en[i])
                begin
                    bytes_reg[i] <= load_char;
                end
            end
        end
    end

    assign pat_bytes      = bytes_reg;
    assign view.mask      = mask_reg;
    assign view.star      = star_reg & mask_reg;
    assign view.end_pos   = end_reg;
    assign view.start_vec = start_reg;
    assign view.overflow  = ovf_reg;

`ifndef NO_ASSERTIONS
    a_end_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(end_reg))
        else $error("pattern end position not one-hot");

    a_mask_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        (end_reg - sgm_pkg::POS_W'(1)) == {1'b0, mask_reg})
        else $error("pattern mask disagrees with end position");
`endif

endmodule

// File: design/sgm_automaton.sv
module sgm_automaton (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  sgm_pkg::cmd_t            command,
    input  logic [7:0]               char_value,
    input  logic                     first,
    input  logic                     last,
    input  logic [7:0]               pat_bytes [sgm_pkg::PATTERN_MAX],
    input  sgm_pkg::pat_view_t       view,
    output sgm_pkg::result_t         res
);

    logic [sgm_pkg::POS_W-1:0]          active_reg;
    logic [sgm_pkg::POS_W-1:0]          active_next;
    logic                               at_start_reg;
    logic                               at_start_next;

    logic [sgm_pkg::POS_W-1:0]          act_in;
    logic [sgm_pkg::PATTERN_MAX-1:0]    eq;
    logic [sgm_pkg::POS_W-1:0]          stepped;
    logic [sgm_pkg::POS_W-1:0]          closed;

    // every text step leaves active_reg wildcard-closed
    always_comb
    begin
        act_in = (first || at_start_reg) ? view.start_vec : active_reg;
        for (int i = 0; i < sgm_pkg::PATTERN_MAX; i++)
        begin
            eq[i] = (pat_bytes[i] == char_value);
        end
        stepped = {1'b0, act_in[sgm_pkg::PATTERN_MAX-1:0] & view.star}
                | {act_in[sgm_pkg::PATTERN_MAX-1:0] & view.mask & ~view.star & eq, 1'b0};
        closed  = sgm_pkg::star_closure(stepped, view.star);

        active_next   = active_reg;
        at_start_next = at_start_reg;
        res           = '0;
        if (en)
        begin
            case (command)
                sgm_pkg::CMD_LOAD:
                begin
                    at_start_next = 1'b1;
                end
                sgm_pkg::CMD_TEXT:
                begin
                    active_next   = closed;
                    at_start_next = 1'b0;
                    if (last)
                    begin
                        res.has_result = 1'b1;
                        res.matched    = (|(closed & view.end_pos)) && !view.overflow;
                        res.overflow   = view.overflow;
                    end
                end
                sgm_pkg::CMD_EVAL:
                begin
                    at_start_next  = 1'b1;
                    res.has_result = 1'b1;
                    res.matched    = (|(view.start_vec & view.end_pos)) && !view.overflow;
                    res.overflow   = view.overflow;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= sgm_pkg::POS_W'(1);
            at_start_reg <= 1'b1;
        end
        else
        begin
            active_reg   <= active_next;
            at_start_reg <= at_start_next;
        end
    end

endmodule

// File: design/star_glob_matcher_core.sv
// Anchored glob matcher where '*' matches any run of bytes (including none)
// and every other byte must match exactly. Load a pattern with command 0
// (first=1 on its first byte; up to 32 bytes, more sets pattern_overflow and
// forces matched=0). Stream text with command 1, first=1 on the first byte
// and last=1 on the final one; the final byte gives one result. Command 2
// evaluates the empty text and always gives a result. Command 3 is ignored.
// One item per clock is taken while the output is not stalled; an item's result
// passes the input register, then the result register. The cycle is set by the
// position-vector update: 32 parallel byte compares plus one 33-bit carry
// chain that spreads active positions across runs of wildcards. No clearing
// pass is needed after reset. While a result waits at a stalled output, the
// input register still takes one more item; after that in_stall stays high
// until the waiting result leaves.
module star_glob_matcher_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  char_value,
    input  logic        first,
    input  logic        last,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic        pattern_overflow
);

    // input register
    logic        s1_valid_reg;
    logic [1:0]  s1_cmd_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;

    // result register
    logic        out_valid_reg;
    logic        matched_reg;
    logic        ovf_reg;

    logic        advance;    // pipeline may move this cycle
    logic        exec;       // item in the input register is processed
    logic        load_en;

    logic [7:0]          pat_bytes [sgm_pkg::PATTERN_MAX];
    sgm_pkg::pat_view_t  view;
    sgm_pkg::result_t    res;

    assign advance  = !(out_valid_reg && out_stall);
    assign exec     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign load_en  = exec && (sgm_pkg::cmd_t'(s1_cmd_reg) == sgm_pkg::CMD_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || advance)
        begin
            s1_cmd_reg   <= command;
            s1_char_reg  <= char_value;
            s1_first_reg <= first;
            s1_last_reg  <= last;
        end
    end

    sgm_pattern_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_en),
        .load_first (s1_first_reg),
        .load_char  (s1_char_reg),
        .pat_bytes  (pat_bytes),
        .view       (view)
    );

    sgm_automaton u_auto (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (exec),
        .command    (sgm_pkg::cmd_t'(s1_cmd_reg)),
        .char_value (s1_char_reg),
        .first      (s1_first_reg),
        .last       (s1_last_reg),
        .pat_bytes  (pat_bytes),
        .view       (view),
        .res        (res)
    );

    // Result register holds while the consumer stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= exec && res.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            matched_reg <= res.matched;
            ovf_reg     <= res.overflow;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_reg;

`ifndef NO_ASSERTIONS
    a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && ovf_reg))
        else $error("match reported with overflowed pattern");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in the input register");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |=> !out_valid_reg)
        else $error("pattern load produced a result");
`endif

endmodule
